// ===== rtl/core/lcd_nibble_write_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// LCD nibble write sequencer assertion macros
// Clocked assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LCD_NIBBLE_WRITE_SEQUENCER_TOP_MACROS_SVH
`define LCD_NIBBLE_WRITE_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define LNWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LNWS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LNWS_ASSERT(lbl, clk, rst_n, prop, msg)

`define LNWS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/lnws_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD nibble write sequencer package
// Widths, codes, sequencer phases and the init command list.
// ----------------------------------------------------------------------------
package lnws_pkg;

    localparam int COUNT_W    = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int STEP_W     = 3;
    localparam int INIT_COUNT = 6;

    localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_COUNT - 1);

    localparam logic [COUNT_W-1:0] RST_PULSE_TICKS = COUNT_W'(2000);
    localparam logic [COUNT_W-1:0] RST_GAP_TICKS   = COUNT_W'(200000);
    localparam logic [COUNT_W-1:0] RST_POWER_TICKS = COUNT_W'(20000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PULSE_TICKS = 2'd0,
        CFG_GAP_TICKS   = 2'd1,
        CFG_POWER_TICKS = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_addr;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_INIT  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_POWER = 3'd1,
        PH_HIGH  = 3'd2,
        PH_GAP   = 3'd3,
        PH_LOW   = 3'd4,
        PH_NEXT  = 3'd5
    } t_phase;

    typedef struct packed {
        logic       rejected;
        logic       busy;
        logic [3:0] data_nibble;
        logic       read_write_pin;
        logic       select_pin;
        logic       enable_pin;
    } t_result;

    function automatic logic [7:0] init_cmd(input logic [STEP_W-1:0] step);
        logic [7:0] cmd;
        unique case (step)
            3'd0:    cmd = 8'h33;
            3'd1:    cmd = 8'h32;
            3'd2:    cmd = 8'h28;
            3'd3:    cmd = 8'h0C;
            3'd4:    cmd = 8'h06;
            3'd5:    cmd = 8'h01;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

    function automatic logic [COUNT_W-1:0] count_load(input logic [COUNT_W-1:0] v);
        return (v == '0) ? COUNT_W'(1) : v;
    endfunction

endpackage

// ===== rtl/core/lcd_nibble_write_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// LCD nibble write sequencer
// Character LCD driver over a 4-bit bus: ticks, byte writes and init.
// ----------------------------------------------------------------------------
//  channel   direction  transfer when                  payload
//  s_axis    in         s_axis_tvalid & s_axis_tready  tdata byte, tuser mode/select
//  m_axis    out        m_axis_tvalid & m_axis_tready  tdata pin levels and status
//  cfg       in         i_cfg_we                       i_cfg_addr, i_cfg_wdata
//
//  One item per cycle while s_axis_tready is high; each item updates the
//  sequencer state and the output register in the cycle it is taken.
//  The output register sets the only stall path: s_axis_tready is low only
//  while a result is held and m_axis_tready is low.
//  Synchronous active-low reset returns the sequencer to idle and restores
//  the default tick counts; no clearing pass.
// ----------------------------------------------------------------------------
`include "lcd_nibble_write_sequencer_top_macros.svh"

module lcd_nibble_write_sequencer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lnws_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lnws_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] byte_value
    input  logic [2:0]                    s_axis_tuser,  // [1:0] mode, [2] select_data
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] enable_pin, [1] select_pin, [2] read_write_pin, [6:3] data_nibble,
    // [7] busy_res, [8] rejected, [15:9] zero
    output logic [15:0]                   m_axis_tdata
);

    logic [lnws_pkg::COUNT_W-1:0] r_pulse_ticks;
    logic [lnws_pkg::COUNT_W-1:0] r_gap_ticks;
    logic [lnws_pkg::COUNT_W-1:0] r_power_ticks;

    lnws_pkg::t_phase             r_phase, n_phase;
    logic [lnws_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]                   r_held_byte, n_held_byte;
    logic                         r_held_sel, n_held_sel;
    logic [lnws_pkg::STEP_W-1:0]  r_init_step, n_init_step;
    logic                         r_init_active, n_init_active;
    logic                         r_en, n_en;
    logic [3:0]                   r_nib, n_nib;

    logic                         r_out_valid;
    lnws_pkg::t_result            r_out;
    lnws_pkg::t_result            w_res;

    logic                         w_accept;
    lnws_pkg::t_mode              w_mode;
    logic                         w_busy;
    logic                         w_expire;
    logic                         w_rej;
    logic [7:0]                   w_init_cmd;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_mode        = lnws_pkg::t_mode'(s_axis_tuser[1:0]);
    assign w_busy        = (r_phase != lnws_pkg::PH_IDLE);
    assign w_expire      = w_busy && (r_cnt <= lnws_pkg::COUNT_W'(1));
    assign w_init_cmd    = lnws_pkg::init_cmd(r_init_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks <= lnws_pkg::RST_PULSE_TICKS;
            r_gap_ticks   <= lnws_pkg::RST_GAP_TICKS;
            r_power_ticks <= lnws_pkg::RST_POWER_TICKS;
        end else if (i_cfg_we) begin
            unique case (lnws_pkg::t_cfg_addr'(i_cfg_addr))
                lnws_pkg::CFG_PULSE_TICKS: r_pulse_ticks <= i_cfg_wdata;
                lnws_pkg::CFG_GAP_TICKS:   r_gap_ticks   <= i_cfg_wdata;
                lnws_pkg::CFG_POWER_TICKS: r_power_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            unique case (w_mode)
                lnws_pkg::MODE_TICK: begin
                    if (w_expire) begin
                        unique case (r_phase)
                            lnws_pkg::PH_POWER,
                            lnws_pkg::PH_NEXT: n_phase = lnws_pkg::PH_HIGH;
                            lnws_pkg::PH_HIGH: n_phase = lnws_pkg::PH_GAP;
                            lnws_pkg::PH_GAP:  n_phase = lnws_pkg::PH_LOW;
                            lnws_pkg::PH_LOW: begin
                                if (r_init_active && (r_init_step < lnws_pkg::INIT_LAST)) begin
                                    n_phase = lnws_pkg::PH_NEXT;
                                end else begin
                                    n_phase = lnws_pkg::PH_IDLE;
                                end
                            end
                            default: n_phase = lnws_pkg::PH_IDLE;
                        endcase
                    end
                end
                lnws_pkg::MODE_WRITE: begin
                    if (!w_busy) begin
                        n_phase = lnws_pkg::PH_HIGH;
                    end
                end
                lnws_pkg::MODE_INIT: begin
                    if (!w_busy) begin
                        n_phase = lnws_pkg::PH_POWER;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_cnt         = r_cnt;
        n_held_byte   = r_held_byte;
        n_held_sel    = r_held_sel;
        n_init_step   = r_init_step;
        n_init_active = r_init_active;
        n_en          = r_en;
        n_nib         = r_nib;
        w_rej         = 1'b0;
        if (w_accept) begin
            unique case (w_mode)
                lnws_pkg::MODE_TICK: begin
                    if (w_busy && !w_expire) begin
                        n_cnt = r_cnt - lnws_pkg::COUNT_W'(1);
                    end else if (w_expire) begin
                        unique case (r_phase)
                            lnws_pkg::PH_POWER,
                            lnws_pkg::PH_NEXT: begin
                                n_held_byte = w_init_cmd;
                                n_held_sel  = 1'b0;
                                n_nib       = w_init_cmd[7:4];
                                n_en        = 1'b1;
                                n_cnt       = lnws_pkg::count_load(r_pulse_ticks);
                            end
                            lnws_pkg::PH_HIGH: begin
                                n_en  = 1'b0;
                                n_cnt = lnws_pkg::count_load(r_gap_ticks);
                            end
                            lnws_pkg::PH_GAP: begin
                                n_nib = r_held_byte[3:0];
                                n_en  = 1'b1;
                                n_cnt = lnws_pkg::count_load(r_pulse_ticks);
                            end
                            lnws_pkg::PH_LOW: begin
                                n_en = 1'b0;
                                if (r_init_active && (r_init_step < lnws_pkg::INIT_LAST)) begin
                                    n_init_step = r_init_step + lnws_pkg::STEP_W'(1);
                                    n_cnt       = lnws_pkg::COUNT_W'(1);
                                end else begin
                                    n_init_active = 1'b0;
                                    n_init_step   = '0;
                                    n_cnt         = '0;
                                end
                            end
                            default: begin
                                n_en  = 1'b0;
                                n_cnt = '0;
                            end
                        endcase
                    end
                end
                lnws_pkg::MODE_WRITE: begin
                    if (w_busy) begin
                        w_rej = 1'b1;
                    end else begin
                        n_held_byte = s_axis_tdata;
                        n_held_sel  = s_axis_tuser[2];
                        n_nib       = s_axis_tdata[7:4];
                        n_en        = 1'b1;
                        n_cnt       = lnws_pkg::count_load(r_pulse_ticks);
                    end
                end
                lnws_pkg::MODE_INIT: begin
                    if (w_busy) begin
                        w_rej = 1'b1;
                    end else begin
                        n_init_active = 1'b1;
                        n_init_step   = '0;
                        n_held_sel    = 1'b0;
                        n_en          = 1'b0;
                        n_cnt         = lnws_pkg::count_load(r_power_ticks);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        w_res.enable_pin     = n_en;
        w_res.select_pin     = n_held_sel;
        w_res.read_write_pin = 1'b0;
        w_res.data_nibble    = n_nib;
        w_res.busy           = (n_phase != lnws_pkg::PH_IDLE);
        w_res.rejected       = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= lnws_pkg::PH_IDLE;
            r_cnt         <= '0;
            r_held_byte   <= '0;
            r_held_sel    <= 1'b0;
            r_init_step   <= '0;
            r_init_active <= 1'b0;
            r_en          <= 1'b0;
            r_nib         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_cnt         <= n_cnt;
            r_held_byte   <= n_held_byte;
            r_held_sel    <= n_held_sel;
            r_init_step   <= n_init_step;
            r_init_active <= n_init_active;
            r_en          <= n_en;
            r_nib         <= n_nib;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

    `LNWS_ASSERT(a_idle_quiet, i_clk, i_rst_n, (r_phase == lnws_pkg::PH_IDLE) |-> ((r_cnt == '0) && !r_en && !r_init_active), "idle phase with live counter or strobe")
    `LNWS_ASSERT(a_en_in_pulse, i_clk, i_rst_n, r_en |-> ((r_phase == lnws_pkg::PH_HIGH) || (r_phase == lnws_pkg::PH_LOW)), "enable high outside a pulse phase")
    `LNWS_ASSERT_NEVER(a_step_range, i_clk, i_rst_n, r_init_step > lnws_pkg::INIT_LAST, "init step past command list")
    `LNWS_ASSERT(a_reject_holds, i_clk, i_rst_n, (w_accept && w_busy && ((w_mode == lnws_pkg::MODE_WRITE) || (w_mode == lnws_pkg::MODE_INIT))) |=> ($stable(r_phase) && $stable(r_cnt) && $stable(r_held_byte)), "rejected request changed state")
    `LNWS_ASSERT(a_stall_blocks, i_clk, i_rst_n, (r_out_valid && !m_axis_tready) |-> !s_axis_tready, "input taken while result stalled")

endmodule

// ===== tb/lcd_nibble_write_sequencer_top_test.sv =====
// ----------------------------------------------------------------------------
// LCD nibble write sequencer testbench
// Streams ticks, byte writes and init requests into the sequencer, predicts
// the pin levels and status after every item, and compares each result
// transfer with the oldest prediction under random bursts and stalls.
// ----------------------------------------------------------------------------
module lcd_nibble_write_sequencer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [47:0] INIT_SEQUENCE = {8'h01, 8'h06, 8'h0C, 8'h28, 8'h32, 8'h33};

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [lnws_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [lnws_pkg::COUNT_W-1:0]    i_cfg_wdata = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;   // [7:0] byte_value
    logic [2:0]                      s_axis_tuser = '0;   // [1:0] mode, [2] select_data
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [0] enable_pin, [1] select_pin, [2] read_write_pin, [6:3] data_nibble,
    // [7] busy_res, [8] rejected, [15:9] zero
    logic [15:0]                     m_axis_tdata;

    lcd_nibble_write_sequencer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sequencer copy
    lnws_pkg::t_phase seq_phase;
    logic [19:0]      seq_count;
    logic [7:0]       seq_byte;
    logic             seq_select;
    logic [2:0]       seq_step;
    logic             seq_init_on;
    logic             seq_enable;
    logic [3:0]       seq_nibble;
    logic [19:0]      pulse_ticks;
    logic [19:0]      gap_ticks;
    logic [19:0]      power_ticks;

    lnws_pkg::t_result pending_pins[$];
    int unsigned  failures = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  burst_left = 0;
    bit           tx_gaps = 1'b1;
    int unsigned  rx_stall_pct = 0;
    bit           rx_hold_req = 1'b0;
    int unsigned  rx_hold_left = 0;

    function automatic logic [19:0] ticks_or_one(input logic [19:0] v);
        return (v == '0) ? 20'd1 : v;
    endfunction

    function automatic void raise_enable(input logic [3:0] nib);
        seq_nibble = nib;
        seq_enable = 1'b1;
        seq_count  = ticks_or_one(pulse_ticks);
    endfunction

    function automatic lnws_pkg::t_result predict_pins(input lnws_pkg::t_mode m,
                                                       input logic [7:0] b,
                                                       input logic s);
        lnws_pkg::t_result r;
        logic    busy;
        logic    rej;
        busy = (seq_phase != lnws_pkg::PH_IDLE);
        rej  = 1'b0;
        case (m)
            lnws_pkg::MODE_TICK: begin
                if (busy) begin
                    if (seq_count != '0) seq_count--;
                    if (seq_count == '0) begin
                        case (seq_phase)
                            lnws_pkg::PH_POWER, lnws_pkg::PH_NEXT: begin
                                seq_byte   = INIT_SEQUENCE[seq_step*8 +: 8];
                                seq_select = 1'b0;
                                raise_enable(seq_byte[7:4]);
                                seq_phase  = lnws_pkg::PH_HIGH;
                            end
                            lnws_pkg::PH_HIGH: begin
                                seq_enable = 1'b0;
                                seq_count  = ticks_or_one(gap_ticks);
                                seq_phase  = lnws_pkg::PH_GAP;
                            end
                            lnws_pkg::PH_GAP: begin
                                raise_enable(seq_byte[3:0]);
                                seq_phase = lnws_pkg::PH_LOW;
                            end
                            lnws_pkg::PH_LOW: begin
                                seq_enable = 1'b0;
                                if (seq_init_on && seq_step < 3'(lnws_pkg::INIT_COUNT - 1)) begin
                                    seq_step++;
                                    seq_count = 20'd1;
                                    seq_phase = lnws_pkg::PH_NEXT;
                                end else begin
                                    seq_init_on = 1'b0;
                                    seq_step    = '0;
                                    seq_count   = '0;
                                    seq_phase   = lnws_pkg::PH_IDLE;
                                end
                            end
                            default: begin
                                seq_phase  = lnws_pkg::PH_IDLE;
                                seq_enable = 1'b0;
                                seq_count  = '0;
                            end
                        endcase
                    end
                end
            end
            lnws_pkg::MODE_WRITE: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    seq_byte   = b;
                    seq_select = s;
                    raise_enable(b[7:4]);
                    seq_phase  = lnws_pkg::PH_HIGH;
                end
            end
            lnws_pkg::MODE_INIT: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    seq_init_on = 1'b1;
                    seq_step    = '0;
                    seq_select  = 1'b0;
                    seq_enable  = 1'b0;
                    seq_count   = ticks_or_one(power_ticks);
                    seq_phase   = lnws_pkg::PH_POWER;
                end
            end
            default: ;
        endcase
        r.enable_pin     = seq_enable;
        r.select_pin     = seq_select;
        r.read_write_pin = 1'b0;
        r.data_nibble    = seq_nibble;
        r.busy           = (seq_phase != lnws_pkg::PH_IDLE);
        r.rejected       = rej;
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        lnws_pkg::t_result got;
        lnws_pkg::t_result want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_cfg_we) begin
                quiet_cycles = 0;
                case (lnws_pkg::t_cfg_addr'(i_cfg_addr))
                    lnws_pkg::CFG_PULSE_TICKS: pulse_ticks = i_cfg_wdata;
                    lnws_pkg::CFG_GAP_TICKS:   gap_ticks   = i_cfg_wdata;
                    lnws_pkg::CFG_POWER_TICKS: power_ticks = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                quiet_cycles = 0;
                pending_pins.push_back(predict_pins(lnws_pkg::t_mode'(s_axis_tuser[1:0]),
                                                    s_axis_tdata, s_axis_tuser[2]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_cycles = 0;
                got = lnws_pkg::t_result'(m_axis_tdata[8:0]);
                if (pending_pins.size() == 0) begin
                    failures++;
                    $display("%0t: transfer with nothing pending, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = pending_pins.pop_front();
                    compare_field("enable_pin", want.enable_pin, got.enable_pin);
                    compare_field("select_pin", want.select_pin, got.select_pin);
                    compare_field("read_write_pin", want.read_write_pin, got.read_write_pin);
                    compare_field("data_nibble", want.data_nibble, got.data_nibble);
                    compare_field("busy_res", want.busy, got.busy);
                    compare_field("rejected", want.rejected, got.rejected);
                    compare_field("tdata padding", 0, m_axis_tdata[15:9]);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("lcd_nibble_write_sequencer_top_test: FAIL");
        $finish;
    end

    task automatic send_item(input lnws_pkg::t_mode m, input logic [7:0] b, input logic s);
        int unsigned pause;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            pause = tx_gaps ? $urandom_range(0, 4) : 0;
            if (pause > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (pause) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {s, m};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_ticks(input int unsigned count);
        repeat (count) send_item(lnws_pkg::MODE_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_random_items(input int unsigned count);
        int unsigned     pick;
        lnws_pkg::t_mode m;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 64)      m = lnws_pkg::MODE_TICK;
            else if (pick < 86) m = lnws_pkg::MODE_WRITE;
            else if (pick < 93) m = lnws_pkg::MODE_INIT;
            else                m = lnws_pkg::MODE_NONE;
            send_item(m, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input lnws_pkg::t_cfg_addr a, input logic [19:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [19:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return 20'd0;
            1, 2, 3: return 20'd1;
            9:       return 20'($urandom_range(10, 40));
            default: return 20'($urandom_range(2, 5));
        endcase
    endfunction

    task automatic test_idle_items;
        send_item(lnws_pkg::MODE_TICK, 8'hFF, 1'b1);
        send_item(lnws_pkg::MODE_NONE, 8'hA5, 1'b1);
        send_item(lnws_pkg::MODE_TICK, 8'h00, 1'b0);
        send_item(lnws_pkg::MODE_NONE, 8'h5A, 1'b0);
        drain();
    endtask

    task automatic test_busy_reconfig;
        write_reg(lnws_pkg::CFG_PULSE_TICKS, 20'd30);
        send_item(lnws_pkg::MODE_WRITE, 8'hC3, 1'b1);
        send_ticks(10);
        send_item(lnws_pkg::MODE_WRITE, 8'h12, 1'b0);
        send_item(lnws_pkg::MODE_INIT, 8'h00, 1'b0);
        send_item(lnws_pkg::MODE_NONE, 8'hFF, 1'b1);
        drain();
        write_reg(lnws_pkg::CFG_PULSE_TICKS, 20'd3);
        write_reg(lnws_pkg::CFG_GAP_TICKS, 20'd0);
        write_reg(lnws_pkg::CFG_POWER_TICKS, 20'd2);
        tx_gaps = 1'b0;
        send_ticks(40);
        tx_gaps = 1'b1;
        drain();
    endtask

    task automatic test_write_extremes;
        write_reg(lnws_pkg::CFG_PULSE_TICKS, 20'd0);
        write_reg(lnws_pkg::CFG_GAP_TICKS, 20'd2);
        write_reg(lnws_pkg::CFG_POWER_TICKS, 20'd0);
        send_item(lnws_pkg::MODE_WRITE, 8'h00, 1'b0);
        send_ticks(4);
        send_item(lnws_pkg::MODE_WRITE, 8'hFF, 1'b1);
        send_item(lnws_pkg::MODE_WRITE, 8'h5A, 1'b0);
        send_item(lnws_pkg::MODE_INIT, 8'hFF, 1'b1);
        send_item(lnws_pkg::MODE_NONE, 8'h81, 1'b1);
        send_ticks(5);
        drain();
    endtask

    task automatic test_init_sequence;
        write_reg(lnws_pkg::CFG_PULSE_TICKS, 20'd1);
        write_reg(lnws_pkg::CFG_GAP_TICKS, 20'd1);
        write_reg(lnws_pkg::CFG_POWER_TICKS, 20'd3);
        send_item(lnws_pkg::MODE_INIT, 8'h00, 1'b1);
        send_item(lnws_pkg::MODE_WRITE, 8'hE7, 1'b1);
        send_item(lnws_pkg::MODE_INIT, 8'h00, 1'b0);
        send_ticks(28);
        drain();
    endtask

    task automatic test_random_mix;
        for (int p = 0; p < 6; p++) begin
            write_reg(lnws_pkg::CFG_PULSE_TICKS, pick_ticks());
            write_reg(lnws_pkg::CFG_GAP_TICKS, pick_ticks());
            write_reg(lnws_pkg::CFG_POWER_TICKS, pick_ticks());
            tx_gaps      = (p % 3) != 0;
            rx_stall_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 25 : 60);
            send_random_items(225);
            drain();
        end
        tx_gaps      = 1'b1;
        rx_stall_pct = 20;
    endtask

    task automatic test_backpressure;
        write_reg(lnws_pkg::CFG_PULSE_TICKS, 20'd2);
        write_reg(lnws_pkg::CFG_GAP_TICKS, 20'd1);
        write_reg(lnws_pkg::CFG_POWER_TICKS, 20'd4);
        tx_gaps     = 1'b0;
        rx_hold_req = 1'b1;
        send_random_items(150);
        tx_gaps     = 1'b1;
        drain();
    endtask

    task automatic test_max_counts;
        write_reg(lnws_pkg::CFG_PULSE_TICKS, 20'hFFFFF);
        write_reg(lnws_pkg::CFG_GAP_TICKS, 20'hFFFFF);
        write_reg(lnws_pkg::CFG_POWER_TICKS, 20'hFFFFF);
        send_item(lnws_pkg::MODE_WRITE, 8'($urandom), 1'($urandom));
        send_random_items(100);
        drain();
    endtask

    initial begin
        pulse_ticks = lnws_pkg::RST_PULSE_TICKS;
        gap_ticks   = lnws_pkg::RST_GAP_TICKS;
        power_ticks = lnws_pkg::RST_POWER_TICKS;
        seq_phase   = lnws_pkg::PH_IDLE;
        seq_count   = '0;
        seq_byte    = '0;
        seq_select  = 1'b0;
        seq_step    = '0;
        seq_init_on = 1'b0;
        seq_enable  = 1'b0;
        seq_nibble  = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_items();
        test_busy_reconfig();
        test_write_extremes();
        test_init_sequence();
        test_random_mix();
        test_backpressure();
        test_max_counts();

        if (pending_pins.size() != 0) begin
            failures++;
            $display("%0t: results missing, expected 0 pending, actual %0d",
                     $time, pending_pins.size());
        end
        if (failures == 0) begin
            $display("lcd_nibble_write_sequencer_top_test: PASS");
        end else begin
            $display("lcd_nibble_write_sequencer_top_test: FAIL");
        end
        $finish;
    end

endmodule
